// ===== sv/lsr_pkg.sv =====
// ----------------------------------------------------------------------------
// lsr_pkg
// Shared constants and types of the link slot reserver.
// ----------------------------------------------------------------------------
`default_nettype none

package lsr_pkg;

    // field widths
    localparam int TIME_BITS    = 16;
    localparam int LINK_BITS    = 3;
    localparam int STATUS_BITS  = 2;

    // default sizing
    localparam int LINK_COUNT_DEF       = 8;
    localparam int ENTRIES_PER_LINK_DEF = 16;

    // horizon after reset
    localparam logic [TIME_BITS-1:0] HORIZON_RESET = TIME_BITS'(400);

    typedef logic [TIME_BITS-1:0]   t_time;
    typedef logic [STATUS_BITS-1:0] t_status;

    // result status codes
    localparam t_status ST_GRANTED = 2'd0;
    localparam t_status ST_HORIZON = 2'd1;
    localparam t_status ST_FULL    = 2'd2;

endpackage

`default_nettype wire

// ===== sv/lsr_if.sv =====
// ----------------------------------------------------------------------------
// lsr_if
// Valid/ready channels of the link slot reserver: request, response, config.
// ----------------------------------------------------------------------------
`default_nettype none

// reservation request channel
interface lsr_req_if;
    logic                           valid;
    logic                           ready;
    logic [lsr_pkg::LINK_BITS-1:0]  link_index;
    lsr_pkg::t_time                 earliest_time;
    lsr_pkg::t_time                 duration;

    modport source (output valid, output link_index, output earliest_time,
                    output duration, input ready);
    modport sink   (input valid, input link_index, input earliest_time,
                    input duration, output ready);
endinterface

// reservation result channel
interface lsr_rsp_if;
    logic               valid;
    logic               ready;
    lsr_pkg::t_time     granted_start;
    lsr_pkg::t_status   status;

    modport source (output valid, output granted_start, output status, input ready);
    modport sink   (input valid, input granted_start, input status, output ready);
endinterface

// horizon register write channel
interface lsr_cfg_if;
    logic               valid;
    logic               ready;
    lsr_pkg::t_time     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/lsr_ram.sv =====
// ----------------------------------------------------------------------------
// lsr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== sv/link_slot_reserver.sv =====
// ----------------------------------------------------------------------------
// link_slot_reserver
// First-fit reservation of transmission windows in per-link busy tables.
// ----------------------------------------------------------------------------
// Usage: a request transfer on i_req names a link, an earliest arrival time
// and a duration. The block walks that link's busy intervals (sorted by
// start) one entry at a time, finds the first gap that holds the duration at
// or after the arrival, checks the end against the horizon, shifts the later
// entries up by one and writes the new interval. One result transfer on o_rsp
// gives the granted start and a status (granted, past horizon, table full).
// The horizon is written through i_cfg; the user must write it only while the
// block is idle, since i_cfg is always ready and the block does not enforce it.
// The table RAM has one read port with registered data, so every walk or shift
// step spends a read state (S_WRD, S_SRD) and then a compare or write state
// (S_WCMP, S_SWR). A past-horizon reject skips the shift and insert states, a
// full or unknown link goes straight to the result state; after each item the
// sequencer passes through idle again.
// i_req is ready only while the sequencer is idle, also while a result still
// waits in the output register; a stalled receiver holds that result and the
// next item waits before its result is loaded. Reset empties all link tables
// at once through the fill counts and sets the horizon to 400.
// ----------------------------------------------------------------------------
`default_nettype none

module link_slot_reserver #(
    parameter int LINK_COUNT       = lsr_pkg::LINK_COUNT_DEF,
    parameter int ENTRIES_PER_LINK = lsr_pkg::ENTRIES_PER_LINK_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    lsr_req_if.sink    i_req,
    lsr_rsp_if.source  o_rsp,
    lsr_cfg_if.sink    i_cfg
);

    localparam int TB    = lsr_pkg::TIME_BITS;
    localparam int LW    = (LINK_COUNT > 1) ? $clog2(LINK_COUNT) : 1;
    localparam int FW    = $clog2(ENTRIES_PER_LINK + 1);
    localparam int IW    = $clog2(ENTRIES_PER_LINK);
    localparam int DEPTH = LINK_COUNT * ENTRIES_PER_LINK;
    localparam int AW    = $clog2(DEPTH);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WRD  = 3'd1;
    localparam logic [2:0] S_WCMP = 3'd2;
    localparam logic [2:0] S_HCHK = 3'd3;
    localparam logic [2:0] S_SRD  = 3'd4;
    localparam logic [2:0] S_SWR  = 3'd5;
    localparam logic [2:0] S_INS  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]             r_state, n_state;
    lsr_pkg::t_time         r_horizon;
    logic [FW-1:0]          r_fill_tab [LINK_COUNT];
    logic [LW-1:0]          r_link;
    logic [FW-1:0]          r_fill;
    logic [FW-1:0]          r_idx, n_idx;
    logic [FW-1:0]          r_pos, n_pos;
    lsr_pkg::t_time         r_cand, n_cand;
    lsr_pkg::t_time         r_dur;
    lsr_pkg::t_time         r_res_start, n_res_start;
    lsr_pkg::t_status       r_res_status, n_res_status;
    logic                   r_out_valid;
    lsr_pkg::t_time         r_out_start;
    lsr_pkg::t_status       r_out_status;

    logic                   req_xfer;
    logic                   link_ok;
    logic [LW-1:0]          in_link;
    logic [FW-1:0]          in_fill;
    logic [TB:0]            sum;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [2*TB-1:0]        ram_wdata, ram_rdata;
    lsr_pkg::t_time         ent_start, ent_end;
    logic                   out_free;

    // entry address within the flat table
    function automatic logic [AW-1:0] entry_addr(input logic [LW-1:0] link,
                                                 input logic [IW-1:0] idx);
        entry_addr = AW'(32'(link) * ENTRIES_PER_LINK + 32'(idx));
    endfunction

    // handshakes
    assign i_req.ready = (r_state == S_IDLE);
    assign req_xfer    = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.granted_start = r_out_start;
    assign o_rsp.status        = r_out_status;
    assign out_free            = !r_out_valid || o_rsp.ready;

    // request link decode and fill lookup
    assign link_ok = (32'(i_req.link_index) < LINK_COUNT);
    assign in_link = LW'(32'(i_req.link_index));
    assign in_fill = link_ok ? r_fill_tab[in_link] : FW'(0);

    // shared adder: end of the candidate window, one bit wider
    assign sum = {1'b0, r_cand} + {1'b0, r_dur};

    assign ent_start = ram_rdata[2*TB-1:TB];
    assign ent_end   = ram_rdata[TB-1:0];

    // table ram ports
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = entry_addr(r_link, r_pos[IW-1:0]);
        ram_wdata = {r_cand, sum[TB-1:0]};
        ram_raddr = entry_addr(r_link, r_idx[IW-1:0]);
        unique case (r_state)
            S_SRD: begin
                ram_raddr = entry_addr(r_link, IW'(r_idx - FW'(1)));
            end
            S_SWR: begin
                ram_we    = 1'b1;
                ram_waddr = entry_addr(r_link, r_idx[IW-1:0]);
                ram_wdata = ram_rdata;
            end
            S_INS: begin
                ram_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    lsr_ram #(
        .WIDTH (2 * TB),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // sequencer next state
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_cand       = r_cand;
        n_res_start  = r_res_start;
        n_res_status = r_res_status;
        unique case (r_state)
            S_IDLE: begin
                if (req_xfer) begin
                    n_cand = i_req.earliest_time;
                    n_idx  = '0;
                    n_pos  = in_fill;
                    if (!link_ok || in_fill >= FW'(ENTRIES_PER_LINK)) begin
                        n_res_start  = '0;
                        n_res_status = lsr_pkg::ST_FULL;
                        n_state      = S_DONE;
                    end else if (in_fill == '0) begin
                        n_state = S_HCHK;
                    end else begin
                        n_state = S_WRD;
                    end
                end
            end
            S_WRD: begin
                n_state = S_WCMP;
            end
            S_WCMP: begin
                if (sum <= {1'b0, ent_start}) begin
                    n_pos   = r_idx;
                    n_state = S_HCHK;
                end else begin
                    if (ent_end > r_cand) begin
                        n_cand = ent_end;
                    end
                    n_idx = r_idx + FW'(1);
                    if (r_idx + FW'(1) == r_fill) begin
                        n_state = S_HCHK;
                    end else begin
                        n_state = S_WRD;
                    end
                end
            end
            S_HCHK: begin
                n_idx = r_fill;
                if (sum > {1'b0, r_horizon}) begin
                    n_res_start  = '0;
                    n_res_status = lsr_pkg::ST_HORIZON;
                    n_state      = S_DONE;
                end else if (r_fill > r_pos) begin
                    n_state = S_SRD;
                end else begin
                    n_state = S_INS;
                end
            end
            S_SRD: begin
                n_state = S_SWR;
            end
            S_SWR: begin
                n_idx = r_idx - FW'(1);
                if (r_idx - FW'(1) > r_pos) begin
                    n_state = S_SRD;
                end else begin
                    n_state = S_INS;
                end
            end
            S_INS: begin
                n_res_start  = r_cand;
                n_res_status = lsr_pkg::ST_GRANTED;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_horizon   <= lsr_pkg::HORIZON_RESET;
            r_out_valid <= 1'b0;
            for (int k = 0; k < LINK_COUNT; k++) begin
                r_fill_tab[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_horizon <= i_cfg.data;
            end
            if (r_state == S_INS) begin
                r_fill_tab[r_link] <= r_fill + FW'(1);
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_pos        <= n_pos;
        r_cand       <= n_cand;
        r_res_start  <= n_res_start;
        r_res_status <= n_res_status;
        if (req_xfer) begin
            r_link <= in_link;
            r_fill <= in_fill;
            r_dur  <= i_req.duration;
        end
        if (r_state == S_DONE && out_free) begin
            r_out_start  <= r_res_start;
            r_out_status <= r_res_status;
        end
    end

endmodule

`default_nettype wire

// ===== verif/lsr_grant_monitor.sv =====
// ----------------------------------------------------------------------------
// lsr_grant_monitor
// Watches the request, result and horizon channels of the link slot reserver.
// Keeps its own copy of the busy tables, works out the grant for every
// request transfer and compares each result transfer against the oldest one.
// ----------------------------------------------------------------------------
`default_nettype none

module lsr_grant_monitor (
    input  wire  i_clk,
    input  wire  i_rst_n,
    lsr_req_if   req_ch,
    lsr_rsp_if   rsp_ch,
    lsr_cfg_if   cfg_ch,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int LINKS   = lsr_pkg::LINK_COUNT_DEF;
    localparam int ENTRIES = lsr_pkg::ENTRIES_PER_LINK_DEF;
    localparam int TBITS   = lsr_pkg::TIME_BITS;

    typedef logic [TBITS:0] t_wide;

    typedef struct packed {
        lsr_pkg::t_time   grant_start;
        lsr_pkg::t_status grant_status;
    } t_grant;

    // shadow of the block's state
    lsr_pkg::t_time  horizon;
    lsr_pkg::t_time  busy_start [LINKS][ENTRIES];
    lsr_pkg::t_time  busy_end   [LINKS][ENTRIES];
    int              busy_fill  [LINKS];
    t_grant          pending_grants [$];

    // first-fit walk, horizon check and sorted insert on the shadow tables
    function automatic t_grant first_fit(logic [lsr_pkg::LINK_BITS-1:0] link_id,
                                         lsr_pkg::t_time arrival,
                                         lsr_pkg::t_time dur);
        t_grant res;
        t_wide  cand;
        t_wide  stop;
        int     n;
        int     pos;
        res.grant_start  = '0;
        res.grant_status = lsr_pkg::ST_FULL;
        if (int'(link_id) >= LINKS) return res;
        n = busy_fill[link_id];
        if (n >= ENTRIES) return res;
        cand = {1'b0, arrival};
        pos  = n;
        for (int i = 0; i < n; i++) begin
            if (cand + dur <= {1'b0, busy_start[link_id][i]}) begin
                pos = i;
                break;
            end
            // repair: the candidate never moves backwards
            if ({1'b0, busy_end[link_id][i]} > cand) cand = {1'b0, busy_end[link_id][i]};
        end
        stop = cand + dur;
        if (stop > {1'b0, horizon}) begin
            res.grant_status = lsr_pkg::ST_HORIZON;
            return res;
        end
        for (int i = n; i > pos; i--) begin
            busy_start[link_id][i] = busy_start[link_id][i-1];
            busy_end[link_id][i]   = busy_end[link_id][i-1];
        end
        busy_start[link_id][pos] = cand[TBITS-1:0];
        busy_end[link_id][pos]   = stop[TBITS-1:0];
        busy_fill[link_id]       = n + 1;
        res.grant_start  = cand[TBITS-1:0];
        res.grant_status = lsr_pkg::ST_GRANTED;
        return res;
    endfunction

    // counts a mismatch, prints only the first few
    task automatic flag_mismatch(input string msg);
        o_fail_count = o_fail_count + 1;
        if (o_fail_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // transfers are taken at the rising edge
    always @(posedge i_clk) begin
        t_grant want;
        if (!i_rst_n) begin
            horizon = lsr_pkg::HORIZON_RESET;
            for (int l = 0; l < LINKS; l++) busy_fill[l] = 0;
            pending_grants.delete();
        end else begin
            // horizon write
            if (cfg_ch.valid && cfg_ch.ready) horizon = cfg_ch.data;

            // request transfer: predict its result
            if (req_ch.valid && req_ch.ready)
                pending_grants.insert(pending_grants.size(),
                                      first_fit(req_ch.link_index, req_ch.earliest_time,
                                                req_ch.duration));

            // result transfer: compare with the oldest prediction
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (pending_grants.size() == 0) begin
                    flag_mismatch($sformatf("result with none expected: start %0d status %0d",
                                            rsp_ch.granted_start, rsp_ch.status));
                end else begin
                    want = pending_grants.pop_front();
                    if (rsp_ch.granted_start !== want.grant_start)
                        flag_mismatch($sformatf("granted_start expected %0d actual %0d",
                                                want.grant_start, rsp_ch.granted_start));
                    if (rsp_ch.status !== want.grant_status)
                        flag_mismatch($sformatf("status expected %0d actual %0d",
                                                want.grant_status, rsp_ch.status));
                end
            end
        end
        o_pending = pending_grants.size();
    end

endmodule

`default_nettype wire

// ===== verif/link_slot_reserver_tb.sv =====
// ----------------------------------------------------------------------------
// link_slot_reserver_tb
// Drives reservation requests and horizon writes into the link slot reserver,
// stalls the result side at random and gives the verdict from the monitor.
// A directed opener covers gaps, repair, horizon edges, zero length, wide
// sums and full tables; random phases follow with changing horizons.
// ----------------------------------------------------------------------------
`default_nettype none

module link_slot_reserver_tb;

    localparam int PHASES          = 17;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int CALM_PHASES     = 2;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    bit   no_idle;
    bit   req_gaps;

    lsr_req_if req_ch ();
    lsr_rsp_if rsp_ch ();
    lsr_cfg_if cfg_ch ();

    link_slot_reserver dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    lsr_grant_monitor grant_mon (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .req_ch       (req_ch),
        .rsp_ch       (rsp_ch),
        .cfg_ch       (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

    // result side: stall bursts mixed with open stretches
    initial begin
        int stall_left;
        int open_left;
        stall_left = 0;
        open_left  = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (no_idle) begin
                rsp_ch.ready <= 1'b1;
            end else if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else if (open_left > 0) begin
                rsp_ch.ready <= 1'b1;
                open_left--;
            end else if ($urandom_range(0, 1) == 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left = $urandom_range(1, 14) - 1;
            end else begin
                rsp_ch.ready <= 1'b1;
                open_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 400)
                                                         : $urandom_range(1, 40);
            end
        end
    end

    // one request transfer; returns at the accepting edge
    task automatic send_req(input int link_id, input int arrival, input int dur);
        int gap;
        @(negedge clk);
        if (!no_idle && req_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.link_index    <= link_id[lsr_pkg::LINK_BITS-1:0];
        req_ch.earliest_time <= arrival[lsr_pkg::TIME_BITS-1:0];
        req_ch.duration      <= dur[lsr_pkg::TIME_BITS-1:0];
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
    endtask

    // horizon write once every result is back
    task automatic set_horizon(input int value);
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value[lsr_pkg::TIME_BITS-1:0];
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // stimulus
    initial begin
        int roll;
        int h;
        int a;
        int d;
        int lo;
        int hi;
        no_idle              = 1'b0;
        req_gaps             = 1'b1;
        req_ch.valid         = 1'b0;
        req_ch.link_index    = '0;
        req_ch.earliest_time = '0;
        req_ch.duration      = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.data          = '0;
        rst_n                = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // reset horizon: gap before an interval, repair, exact horizon end
        send_req(0, 0, 100);
        send_req(0, 0, 50);
        send_req(0, 300, 100);
        send_req(0, 301, 100);
        send_req(0, 200, 100);
        send_req(1, 100, 100);
        // zero length interval in front of a busy one
        send_req(1, 0, 0);
        // wide sum past the top of the time range
        send_req(1, 65535, 65535);
        send_req(2, 0, 400);
        send_req(2, 0, 1);

        // lowered horizon: window fits before an interval but ends past the horizon
        set_horizon(50);
        send_req(1, 0, 60);
        send_req(1, 0, 50);

        // smallest horizon
        set_horizon(1);
        send_req(3, 0, 1);
        send_req(3, 0, 1);
        send_req(3, 1, 0);

        // largest horizon, wide sums at the top
        set_horizon(65535);
        send_req(4, 65535, 1);
        send_req(4, 65534, 1);
        send_req(4, 0, 65535);
        send_req(4, 0, 32768);

        // fill one link, then it answers full whatever the horizon
        for (int k = 0; k < lsr_pkg::ENTRIES_PER_LINK_DEF; k++) send_req(5, 0, 1);
        send_req(5, 0, 1);
        send_req(5, 65535, 65535);
        set_horizon(1);
        send_req(5, 0, 0);

        // random phases
        for (int p = 0; p < PHASES; p++) begin
            case ($urandom_range(0, 5))
                0:       h = 1;
                1:       h = 65535;
                2:       h = 400;
                5:       h = $urandom_range(1, 65535);
                default: h = $urandom_range(100, 4000);
            endcase
            if (p == 0) h = 65535;
            if (p == 1) h = 1;
            set_horizon(h);
            no_idle  = (p >= PHASES - CALM_PHASES);
            req_gaps = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 8) begin
                    // likely to fit: short window inside the horizon
                    a = (h > 1 && $urandom_range(0, 2) != 0) ? $urandom_range(0, h - 1) : 0;
                    d = $urandom_range(1, (h / 16 < 1) ? 1 : h / 16);
                end else if (roll < 20) begin
                    // unshaped noise over every bit
                    a = $urandom_range(0, 65535);
                    d = $urandom_range(0, 65535);
                end else begin
                    // ends past the horizon: rejected, mostly after a walk of the whole table
                    a  = $urandom_range(0, h);
                    lo = h - a + 1;
                    if (lo > 65535) begin
                        a  = $urandom_range(1, h);
                        lo = h - a + 1;
                    end
                    hi = ($urandom_range(0, 1) == 0 && lo + 64 < 65535) ? lo + 64 : 65535;
                    d  = $urandom_range(lo, hi);
                end
                send_req($urandom_range(0, 7), a, d);
            end
        end

        // drain
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
